[hdl/lru_pkg.sv]
// ----------------------------------------------------------------------------
// LRU cache lookup package
// Shared constants and the command/status types between controller and
// datapath.
// ----------------------------------------------------------------------------
package lru_pkg;

  localparam int CacheEntries = 4;
  localparam int IdxW         = $clog2(CacheEntries);
  localparam int RankLimW     = IdxW + 1;
  localparam int KeyW         = 32;
  localparam int DataW        = 32;
  localparam int InTdataW     = 64;
  localparam int OutFieldsW   = 1 + DataW + 1 + KeyW;
  localparam int OutTdataW    = ((OutFieldsW + 7) / 8) * 8;

  typedef struct packed {
    logic            load;
    logic            scan_en;
    logic [IdxW-1:0] scan_idx;
    logic            update;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

[hdl/lru_ctrl.sv]
// ----------------------------------------------------------------------------
// LRU cache controller
// Sequences accept, one-entry-per-cycle scan and the update of one word.
// ----------------------------------------------------------------------------
module lru_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lru_pkg::sts_t sts_i,
  output lru_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StScan   = 3'b010,
    StUpdate = 3'b100
  } state_e;

  state_e                   state_q, state_d;
  logic [lru_pkg::IdxW-1:0] cnt_q, cnt_d;
  logic                     cnt_last;

  assign cnt_last = (cnt_q == lru_pkg::IdxW'(lru_pkg::CacheEntries - 1));

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    in_ready_o     = 1'b0;
    cmd_o.load     = 1'b0;
    cmd_o.scan_en  = 1'b0;
    cmd_o.scan_idx = cnt_q;
    cmd_o.update   = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = StScan;
        end
      end
      StScan: begin
        cmd_o.scan_en = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_last) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        if (sts_i.out_free) begin
          cmd_o.update = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[hdl/lru_dpath.sv]
// ----------------------------------------------------------------------------
// LRU cache datapath
// Entry store, scan trackers, age-rank update and the output word register.
// ----------------------------------------------------------------------------
module lru_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lru_pkg::cmd_t                   cmd_i,
  output lru_pkg::sts_t                   sts_o,
  input  logic [lru_pkg::InTdataW-1:0]    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [lru_pkg::OutTdataW-1:0]   out_data_o
);

  localparam int N  = lru_pkg::CacheEntries;
  localparam int IW = lru_pkg::IdxW;
  localparam int LW = lru_pkg::RankLimW;

  logic [lru_pkg::KeyW-1:0]  key_q;
  logic [lru_pkg::DataW-1:0] data_q;

  logic [N-1:0]              valid_q;
  logic [lru_pkg::KeyW-1:0]  ekey_q  [N];
  logic [lru_pkg::DataW-1:0] edata_q [N];
  logic [IW-1:0]             rank_q  [N];

  logic          hit_found_q, free_found_q, old_found_q;
  logic [IW-1:0] hit_slot_q, free_slot_q, old_slot_q, old_rank_q;

  logic [IW-1:0]             slot;
  logic [LW-1:0]             limit;
  logic [lru_pkg::DataW-1:0] stored;
  logic                      evict;
  logic [lru_pkg::KeyW-1:0]  evict_key;

  logic                      ovalid_q;
  logic                      ohit_q, oevict_q;
  logic [lru_pkg::DataW-1:0] ostored_q;
  logic [lru_pkg::KeyW-1:0]  oekey_q;

  assign sts_o.out_free = !ovalid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q  <= in_data_i[lru_pkg::KeyW-1:0];
      data_q <= in_data_i[lru_pkg::KeyW +: lru_pkg::DataW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      old_found_q  <= 1'b0;
      hit_slot_q   <= '0;
      free_slot_q  <= '0;
      old_slot_q   <= '0;
      old_rank_q   <= '0;
    end else if (cmd_i.load) begin
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      old_found_q  <= 1'b0;
    end else if (cmd_i.scan_en) begin
      if (valid_q[cmd_i.scan_idx]) begin
        if (!hit_found_q && ekey_q[cmd_i.scan_idx] == key_q) begin
          hit_found_q <= 1'b1;
          hit_slot_q  <= cmd_i.scan_idx;
        end
        if (!old_found_q || rank_q[cmd_i.scan_idx] > old_rank_q) begin
          old_found_q <= 1'b1;
          old_slot_q  <= cmd_i.scan_idx;
          old_rank_q  <= rank_q[cmd_i.scan_idx];
        end
      end else if (!free_found_q) begin
        free_found_q <= 1'b1;
        free_slot_q  <= cmd_i.scan_idx;
      end
    end
  end

  always_comb begin
    if (hit_found_q) begin
      slot = hit_slot_q;
    end else if (free_found_q) begin
      slot = free_slot_q;
    end else begin
      slot = old_slot_q;
    end
    limit     = hit_found_q ? {1'b0, rank_q[hit_slot_q]} : LW'(N);
    stored    = hit_found_q ? edata_q[hit_slot_q] : data_q;
    evict     = !hit_found_q && !free_found_q;
    evict_key = evict ? ekey_q[old_slot_q] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < N; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cmd_i.update) begin
      for (int i = 0; i < N; i++) begin
        if (IW'(i) == slot) begin
          valid_q[i] <= 1'b1;
          rank_q[i]  <= '0;
        end else if (valid_q[i] && ({1'b0, rank_q[i]} < limit)) begin
          rank_q[i] <= rank_q[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update && !hit_found_q) begin
      ekey_q[slot]  <= key_q;
      edata_q[slot] <= data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.update) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      ohit_q    <= hit_found_q;
      ostored_q <= stored;
      oevict_q  <= evict;
      oekey_q   <= evict_key;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = {(lru_pkg::OutTdataW - lru_pkg::OutFieldsW)'(0),
                        oekey_q, oevict_q, ostored_q, ohit_q};

endmodule

[hdl/lru_cache_lookup_core.sv]
// ----------------------------------------------------------------------------
// LRU cache lookup core
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// An input word is accepted only in the idle state; the scan then reads one
//   entry per cycle, and the update step, held while the output register is
//   full and not taken, writes the result. A new word is taken after that.
// A finished result may wait in the output register while the next word is
//   accepted and scanned.
// Reset: asynchronous; clears all entry valid bits and age ranks.
module lru_cache_lookup_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] lookup_key, [63:32] data_value
  input  logic [lru_pkg::InTdataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] hit, [32:1] stored_value, [33] evicted, [65:34] evicted_key, [71:66] zero
  output logic [lru_pkg::OutTdataW-1:0] m_axis_tdata
);

  lru_pkg::cmd_t cmd;
  lru_pkg::sts_t sts;

  lru_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lru_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  a_hit_no_evict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[33]))
    else $error("hit and eviction reported together");

  a_evkey_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[33]) |-> (m_axis_tdata[65:34] == '0))
    else $error("evicted key not zero without eviction");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again during scan");

  a_update_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.update |-> sts.out_free)
    else $error("result written over a pending word");

endmodule

[tb/lru_cache_lookup_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU cache lookup core testbench
// Streams key/data words into the core and predicts each result with a cycle-
// free copy of the four-entry LRU store: hit flag, returned data word, and the
// evicted key. Directed fill, eviction and refresh orders come first, then
// random traffic over small hot key sets and fully random keys, with random
// stalls on both streams, one full drain pause and a stall-free tail.
// ----------------------------------------------------------------------------
module lru_cache_lookup_core_tb;

  typedef struct packed {
    logic [lru_pkg::OutTdataW-lru_pkg::OutFieldsW-1:0] pad;
    logic [lru_pkg::KeyW-1:0]                          evicted_key;
    logic                                              evicted;
    logic [lru_pkg::DataW-1:0]                         stored_value;
    logic                                              hit;
  } lookup_result_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [lru_pkg::InTdataW-1:0]  s_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [lru_pkg::OutTdataW-1:0] m_axis_tdata;

  logic                      line_valid [lru_pkg::CacheEntries];
  logic [lru_pkg::KeyW-1:0]  line_key   [lru_pkg::CacheEntries];
  logic [lru_pkg::DataW-1:0] line_data  [lru_pkg::CacheEntries];
  logic [lru_pkg::IdxW-1:0]  line_rank  [lru_pkg::CacheEntries];

  lookup_result_t pending_lookup_results[$];
  int unsigned    mismatch_count = 0;
  int unsigned    stall_pct      = 0;

  lru_cache_lookup_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void age_lines_below(input int unsigned limit);
    for (int i = 0; i < lru_pkg::CacheEntries; i++) begin
      if (line_valid[i] && int'(line_rank[i]) < limit) begin
        line_rank[i] = line_rank[i] + 1'b1;
      end
    end
  endfunction

  function automatic lookup_result_t predict_lookup(input logic [lru_pkg::KeyW-1:0] key,
                                                    input logic [lru_pkg::DataW-1:0] data);
    int             hit_slot;
    int             free_slot;
    int             old_slot;
    int             slot;
    int unsigned    old_rank;
    lookup_result_t res;
    hit_slot  = -1;
    free_slot = -1;
    old_slot  = -1;
    old_rank  = 0;
    res       = '0;
    for (int i = 0; i < lru_pkg::CacheEntries; i++) begin
      if (line_valid[i]) begin
        if (hit_slot < 0 && line_key[i] == key) hit_slot = i;
        if (old_slot < 0 || int'(line_rank[i]) > old_rank) begin
          old_slot = i;
          old_rank = line_rank[i];
        end
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit_slot >= 0) begin
      res.hit          = 1'b1;
      res.stored_value = line_data[hit_slot];
      age_lines_below(line_rank[hit_slot]);
      line_rank[hit_slot] = '0;
    end else begin
      if (free_slot >= 0) begin
        slot = free_slot;
      end else begin
        slot              = old_slot;
        res.evicted       = 1'b1;
        res.evicted_key   = line_key[slot];
        line_valid[slot]  = 1'b0;
      end
      age_lines_below(lru_pkg::CacheEntries);
      line_valid[slot] = 1'b1;
      line_key[slot]   = key;
      line_data[slot]  = data;
      line_rank[slot]  = '0;
      res.stored_value = data;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [lru_pkg::KeyW-1:0] got,
                                 input logic [lru_pkg::KeyW-1:0] want);
    $display("[%0t] result %s: got %h, expected %h", $time, field, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    lookup_result_t got;
    lookup_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_lookup_results.size() == 0) begin
        report_mismatch("word with no pending lookup", got.stored_value, '0);
      end else begin
        want = pending_lookup_results.pop_front();
        if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
        if (got.stored_value !== want.stored_value)
          report_mismatch("stored_value", got.stored_value, want.stored_value);
        if (got.evicted !== want.evicted)
          report_mismatch("evicted", got.evicted, want.evicted);
        if (got.evicted_key !== want.evicted_key)
          report_mismatch("evicted_key", got.evicted_key, want.evicted_key);
        if (got.pad !== want.pad) report_mismatch("padding", got.pad, want.pad);
      end
    end
  end

  initial begin
    int unsigned hold;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        m_axis_tready <= 1'b0;
        hold = $urandom_range(1, 18);
        repeat (hold) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_lookup(input logic [lru_pkg::KeyW-1:0] key,
                             input logic [lru_pkg::DataW-1:0] data);
    int unsigned gap;
    if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      gap = $urandom_range(1, 18);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {data, key};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_lookup_results = {pending_lookup_results, predict_lookup(key, data)};
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_results_drained();
    stop_sending();
    while (pending_lookup_results.size() != 0) @(posedge clk_i);
  endtask

  // first key is zero while every line is still invalid and holds a zero key in the model
  task automatic test_fill_and_evict();
    stall_pct = 20;
    send_lookup(32'h0000_0000, 32'hFFFF_FFFF);
    send_lookup(32'h8000_0000, 32'h0000_0000);
    send_lookup(32'h7FFF_FFFF, 32'hA5A5_5A5A);
    send_lookup(32'hFFFF_FFFF, 32'h5A5A_A5A5);
    send_lookup(32'h0000_0001, 32'h0000_0001);
    send_lookup(32'h8000_0001, 32'h8000_0000);
    stop_sending();
  endtask

  task automatic test_hit_refresh();
    stall_pct = 20;
    send_lookup(32'h7FFF_FFFF, 32'h0000_0000);
    send_lookup(32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_lookup(32'h0000_0001, 32'hFFFF_FFFF);
    send_lookup(32'h0000_0000, 32'h1234_5678);
    send_lookup(32'h8000_0001, 32'h0000_0000);
    send_lookup(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_lookup(32'h0000_0000, 32'h0000_0000);
    send_lookup(32'h8000_0001, 32'hFFFF_FFFF);
    send_lookup(32'hFFFF_FFFF, 32'h0000_0000);
    send_lookup(32'h0000_0001, 32'hDEAD_BEEF);
    send_lookup(32'h7FFF_FFFF, 32'h0F0F_F0F0);
    send_lookup(32'h8000_0001, 32'hF0F0_0F0F);
    stop_sending();
  endtask

  task automatic run_hot_keys(input int unsigned words);
    logic [lru_pkg::KeyW-1:0] hot_keys [8];
    int unsigned              hot_count;
    logic [lru_pkg::KeyW-1:0] key;
    for (int n = 0; n < words; n++) begin
      if (n % 40 == 0) begin
        hot_count = $urandom_range(2, 8);
        foreach (hot_keys[i]) hot_keys[i] = $urandom;
      end
      if ($urandom_range(0, 9) == 0) key = $urandom;
      else key = hot_keys[$urandom_range(0, hot_count - 1)];
      send_lookup(key, $urandom);
    end
    stop_sending();
  endtask

  task automatic test_random_hot_keys();
    stall_pct = 15;
    run_hot_keys(150);
  endtask

  task automatic test_drain_pause();
    stall_pct = 30;
    run_hot_keys(20);
    wait_results_drained();
    run_hot_keys(20);
  endtask

  task automatic test_random_wide();
    stall_pct = 10;
    for (int n = 0; n < 100; n++) begin
      send_lookup($urandom, $urandom);
    end
    stop_sending();
  endtask

  task automatic test_back_to_back();
    stall_pct = 0;
    run_hot_keys(120);
  endtask

  initial begin
    for (int i = 0; i < lru_pkg::CacheEntries; i++) begin
      line_valid[i] = 1'b0;
      line_key[i]   = '0;
      line_data[i]  = '0;
      line_rank[i]  = '0;
    end
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_fill_and_evict();
    test_hit_refresh();
    test_random_hot_keys();
    test_drain_pause();
    test_random_wide();
    test_back_to_back();

    wait_results_drained();
    repeat (4 * (lru_pkg::CacheEntries + 2)) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/lru_pkg.sv
hdl/lru_ctrl.sv
hdl/lru_dpath.sv
hdl/lru_cache_lookup_core.sv
tb/lru_cache_lookup_core_tb.sv
